[rtl/nearest_neighbor_image_scaler_unit_macros.svh]
// Assertion macros for the nearest neighbor image scaler unit.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NNIS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define NNIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/nnis_pkg.sv]
// Shared constants and codes for the nearest neighbor image scaler.
package nnis_pkg;

   localparam int PIX_W      = 16;
   localparam int SW_W       = 11;
   localparam int SH_W       = 10;
   localparam int RATIO_SH   = 16;
   localparam int RATIO_W    = SW_W + RATIO_SH;
   localparam int DIVD_W     = SW_W + RATIO_SH;
   localparam int DIVR_W     = SW_W;
   localparam int AREA_W     = SW_W + SH_W;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 3'd3;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [SW_W-1:0] RESET_SOURCE_WIDTH  = 11'd800;
   localparam logic [SH_W-1:0] RESET_SOURCE_HEIGHT = 10'd480;
   localparam logic [SW_W-1:0] RESET_TARGET_WIDTH  = 11'd800;
   localparam logic [SH_W-1:0] RESET_TARGET_HEIGHT = 10'd480;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DIV_COL = 8'b0000_0010,
      ST_DIV_ROW = 8'b0000_0100,
      ST_MAP     = 8'b0000_1000,
      ST_CLAMP   = 8'b0001_0000,
      ST_ADDR    = 8'b0010_0000,
      ST_READ    = 8'b0100_0000,
      ST_OUT     = 8'b1000_0000
   } state_type;

endpackage

[rtl/nnis_divider.sv]
// Restoring divider, one quotient bit per cycle, for the scale ratios.
module nnis_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [nnis_pkg::DIVD_W-1:0] dividend,
   input  logic [nnis_pkg::DIVR_W-1:0] divisor,
   output logic                        done,
   output logic [nnis_pkg::DIVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(nnis_pkg::DIVD_W + 1);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [nnis_pkg::DIVR_W-1:0] rem_ff, rem_in;
   logic [nnis_pkg::DIVR_W-1:0] div_ff, div_in;
   logic [nnis_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [nnis_pkg::DIVR_W:0]   trial;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[nnis_pkg::DIVD_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(nnis_pkg::DIVD_W);
         rem_in = '0;
         div_in = divisor;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = fits ? nnis_pkg::DIVR_W'(trial - {1'b0, div_ff})
                       : trial[nnis_pkg::DIVR_W-1:0];
         quo_in = {quo_ff[nnis_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/nnis_frame_store.sv]
// Source frame memory: one write port, one registered read port.
module nnis_frame_store #(
   parameter int DEPTH  = 524288,
   parameter int ADDR_W = 19
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [nnis_pkg::PIX_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [nnis_pkg::PIX_W-1:0] rd_data
);

   logic [nnis_pkg::PIX_W-1:0] store_ff [DEPTH];
   logic [nnis_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/nearest_neighbor_image_scaler_unit.sv]
// Nearest neighbor RGB565 scaler: frame store, ratio divider and read sequencer.
//
//   channel   ports                                        handshake
//   request   start, busy, req_cmd, req_pixel_in           start && !busy
//   response  rsp_valid, rsp_pixel_out, rsp_frame_last     one-cycle strobe
//   csr       csr_write_en, csr_index, csr_write_data      write enable only
//
// A load request writes the pixel at the load index.
// A read request steps through map, clamp, address, memory read and output
// states, giving its response in output; the next request is taken from idle.
// The first read of a destination frame first runs the divider for both ratios.
// busy is high during reset and for one cycle after any csr write while the
// frame area product settles. No clearing pass; the response cannot stall.
`include "nearest_neighbor_image_scaler_unit_macros.svh"

module nearest_neighbor_image_scaler_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic [nnis_pkg::PIX_W-1:0]          req_pixel_in,
   output logic                                rsp_valid,
   output logic [nnis_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic                                rsp_frame_last,
   input  logic                                csr_write_en,
   input  logic [nnis_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nnis_pkg::SW_W-1:0]           csr_write_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CMP_W  = (ADDR_W + 1 > nnis_pkg::AREA_W) ? ADDR_W + 1 : nnis_pkg::AREA_W;
   localparam int CW     = (COL_W + 1 > nnis_pkg::SW_W) ? COL_W + 1 : nnis_pkg::SW_W;
   localparam int RW     = (ROW_W + 1 > nnis_pkg::SH_W) ? ROW_W + 1 : nnis_pkg::SH_W;
   localparam int PXW    = COL_W + nnis_pkg::RATIO_W;
   localparam int PYW    = ROW_W + nnis_pkg::RATIO_W;
   localparam int SXW    = PXW - nnis_pkg::RATIO_SH;
   localparam int SYW    = PYW - nnis_pkg::RATIO_SH;
   localparam logic [nnis_pkg::SW_W-1:0] MAX_W_C = nnis_pkg::SW_W'(MAX_WIDTH);
   localparam logic [nnis_pkg::SH_W-1:0] MAX_H_C = nnis_pkg::SH_W'(MAX_HEIGHT);

   function automatic logic [nnis_pkg::SW_W-1:0] clamp_w(input logic [nnis_pkg::SW_W-1:0] v);
      logic [nnis_pkg::SW_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = nnis_pkg::SW_W'(1);
      end else if (int'(v) > MAX_WIDTH) begin
         r = MAX_W_C;
      end
      return r;
   endfunction

   function automatic logic [nnis_pkg::SH_W-1:0] clamp_h(input logic [nnis_pkg::SH_W-1:0] v);
      logic [nnis_pkg::SH_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = nnis_pkg::SH_W'(1);
      end else if (int'(v) > MAX_HEIGHT) begin
         r = MAX_H_C;
      end
      return r;
   endfunction

   nnis_pkg::state_type state_ff, state_in;

   logic [nnis_pkg::SW_W-1:0]    sw_ff, tw_ff;
   logic [nnis_pkg::SH_W-1:0]    sh_ff, th_ff;
   logic                         cfg_pend_ff;
   logic [nnis_pkg::AREA_W-1:0]  area_ff;
   logic [ADDR_W-1:0]            load_ff, load_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [nnis_pkg::RATIO_W-1:0] col_ratio_ff, row_ratio_ff;
   logic                         go_ff, go_in;
   logic [PXW-1:0]               prod_x_ff;
   logic [PYW-1:0]               prod_y_ff;
   logic [nnis_pkg::SW_W-1:0]    sx_ff, sx_in;
   logic [nnis_pkg::SH_W-1:0]    sy_ff, sy_in;
   logic [ADDR_W-1:0]            addr_ff;

   logic                         accept;
   logic                         load_we;
   logic [ADDR_W:0]              load_next;
   logic                         div_done;
   logic [nnis_pkg::DIVD_W-1:0]  div_quot;
   logic [nnis_pkg::DIVD_W-1:0]  div_dividend;
   logic [nnis_pkg::DIVR_W-1:0]  div_divisor;
   logic [SXW-1:0]               px;
   logic [SYW-1:0]               py;
   logic                         col_wrap, row_wrap;
   logic [nnis_pkg::PIX_W-1:0]   rd_data;

   assign busy    = reset || cfg_pend_ff || (state_ff != nnis_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign load_we = accept && (req_cmd == nnis_pkg::CMD_LOAD);

   // config registers hold the clamped sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff       <= clamp_w(nnis_pkg::RESET_SOURCE_WIDTH);
         sh_ff       <= clamp_h(nnis_pkg::RESET_SOURCE_HEIGHT);
         tw_ff       <= clamp_w(nnis_pkg::RESET_TARGET_WIDTH);
         th_ff       <= clamp_h(nnis_pkg::RESET_TARGET_HEIGHT);
         cfg_pend_ff <= 1'b1;
      end else begin
         cfg_pend_ff <= csr_write_en;
         if (csr_write_en) begin
            unique case (csr_index)
               nnis_pkg::CSR_SOURCE_WIDTH:  sw_ff <= clamp_w(csr_write_data);
               nnis_pkg::CSR_SOURCE_HEIGHT: sh_ff <= clamp_h(csr_write_data[nnis_pkg::SH_W-1:0]);
               nnis_pkg::CSR_TARGET_WIDTH:  tw_ff <= clamp_w(csr_write_data);
               nnis_pkg::CSR_TARGET_HEIGHT: th_ff <= clamp_h(csr_write_data[nnis_pkg::SH_W-1:0]);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= nnis_pkg::AREA_W'(sw_ff) * nnis_pkg::AREA_W'(sh_ff);
   end

   // load index wraps at the source frame area
   assign load_next = {1'b0, load_ff} + (ADDR_W + 1)'(1);
   always_comb begin
      load_in = load_ff;
      if (load_we) begin
         if (CMP_W'(load_next) >= CMP_W'(area_ff)) begin
            load_in = '0;
         end else begin
            load_in = load_next[ADDR_W-1:0];
         end
      end
   end

   assign div_dividend = (state_ff == nnis_pkg::ST_DIV_ROW)
                       ? {{(nnis_pkg::SW_W - nnis_pkg::SH_W){1'b0}}, sh_ff,
                          {nnis_pkg::RATIO_SH{1'b0}}}
                       : {sw_ff, {nnis_pkg::RATIO_SH{1'b0}}};
   assign div_divisor  = (state_ff == nnis_pkg::ST_DIV_ROW)
                       ? nnis_pkg::DIVR_W'(th_ff) : tw_ff;

   nnis_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (go_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      go_in    = 1'b0;
      unique case (state_ff)
         nnis_pkg::ST_IDLE: begin
            if (accept && (req_cmd == nnis_pkg::CMD_READ)) begin
               if ((col_ff == '0) && (row_ff == '0)) begin
                  state_in = nnis_pkg::ST_DIV_COL;
                  go_in    = 1'b1;
               end else begin
                  state_in = nnis_pkg::ST_MAP;
               end
            end
         end
         nnis_pkg::ST_DIV_COL: begin
            if (div_done) begin
               state_in = nnis_pkg::ST_DIV_ROW;
               go_in    = 1'b1;
            end
         end
         nnis_pkg::ST_DIV_ROW: begin
            if (div_done) begin
               state_in = nnis_pkg::ST_MAP;
            end
         end
         nnis_pkg::ST_MAP:   state_in = nnis_pkg::ST_CLAMP;
         nnis_pkg::ST_CLAMP: state_in = nnis_pkg::ST_ADDR;
         nnis_pkg::ST_ADDR:  state_in = nnis_pkg::ST_READ;
         nnis_pkg::ST_READ:  state_in = nnis_pkg::ST_OUT;
         nnis_pkg::ST_OUT:   state_in = nnis_pkg::ST_IDLE;
         default:            state_in = nnis_pkg::ST_IDLE;
      endcase
   end

   // destination raster position
   assign col_wrap = (CW'(col_ff) + CW'(1)) >= CW'(tw_ff);
   assign row_wrap = (RW'(row_ff) + RW'(1)) >= RW'(th_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (state_ff == nnis_pkg::ST_OUT) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : ROW_W'(RW'(row_ff) + RW'(1));
         end else begin
            col_in = COL_W'(CW'(col_ff) + CW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nnis_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         load_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         col_ratio_ff <= '0;
         row_ratio_ff <= '0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         load_ff  <= load_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (div_done && (state_ff == nnis_pkg::ST_DIV_COL)) begin
            col_ratio_ff <= div_quot + nnis_pkg::RATIO_W'(1);
         end
         if (div_done && (state_ff == nnis_pkg::ST_DIV_ROW)) begin
            row_ratio_ff <= div_quot + nnis_pkg::RATIO_W'(1);
         end
      end
   end

   // coordinate map: multiply, clamp, then linear address
   assign px = prod_x_ff[PXW-1 -: SXW];
   assign py = prod_y_ff[PYW-1 -: SYW];
   assign sx_in = (px >= SXW'(sw_ff)) ? sw_ff - nnis_pkg::SW_W'(1) : px[nnis_pkg::SW_W-1:0];
   assign sy_in = (py >= SYW'(sh_ff)) ? sh_ff - nnis_pkg::SH_W'(1) : py[nnis_pkg::SH_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == nnis_pkg::ST_MAP) begin
         prod_x_ff <= PXW'(col_ff) * PXW'(col_ratio_ff);
         prod_y_ff <= PYW'(row_ff) * PYW'(row_ratio_ff);
      end
      if (state_ff == nnis_pkg::ST_CLAMP) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (state_ff == nnis_pkg::ST_ADDR) begin
         addr_ff <= ADDR_W'(nnis_pkg::AREA_W'(sy_ff) * nnis_pkg::AREA_W'(sw_ff))
                  + ADDR_W'(sx_ff);
      end
   end

   nnis_frame_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (load_ff),
      .wr_data (req_pixel_in),
      .rd_en   (state_ff == nnis_pkg::ST_READ),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid      = (state_ff == nnis_pkg::ST_OUT);
   assign rsp_pixel_out  = rd_data;
   assign rsp_frame_last = rsp_valid && col_wrap && row_wrap;

   `NNIS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid,
      "response strobe lasted more than one cycle")
   `NNIS_ASSERT_NEXT(a_no_early_rsp, clock, reset, accept, !rsp_valid,
      "response appeared right after a request was accepted")
   `NNIS_ASSERT_SAME(a_div_in_div_state, clock, reset, div_done,
      (state_ff == nnis_pkg::ST_DIV_COL) || (state_ff == nnis_pkg::ST_DIV_ROW),
      "divider finished outside a ratio state")
   `NNIS_ASSERT_SAME(a_last_at_origin, clock, reset, rsp_frame_last,
      (col_in == '0) && (row_in == '0),
      "frame end did not return the raster to the origin")

endmodule
